/* sv/bdc_pkg.sv */
// ----------------------------------------------------------------------------
// Business day counter package
// Widths, constants, sequencer states, command struct and the calendar
// helper functions shared by the counter modules.
// ----------------------------------------------------------------------------
package bdc_pkg;

    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int MASK_W  = 7;

    localparam int YY_W    = 15;
    localparam int Q100_W  = 8;
    localparam int MM_W    = 4;
    localparam int MOFF_W  = 9;
    localparam int SER_W   = 23;
    localparam int QUOT_W  = 21;
    localparam int WD_W    = 3;
    localparam int FULL_W  = 24;

    localparam logic [MASK_W-1:0]  MASK_RESET = 7'd96;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'h3FFFFF;

    localparam int WEEK_DAYS     = 7;
    localparam int YEAR_BIAS     = 400;
    localparam int DAYS_PER_YEAR = 365;
    localparam int EPOCH_WD      = 3;

    localparam int D100_MUL   = 5243;
    localparam int D100_SHIFT = 19;
    localparam int D100_P_W   = YY_W + 13;
    localparam int D7_MUL     = 9586981;
    localparam int D7_SHIFT   = 26;
    localparam int D7_P_W     = SER_W + 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_SERIAL,
        ST_DIFF,
        ST_DIV,
        ST_REM,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic year;
        logic serial;
        logic diff;
        logic div;
        logic rem;
        logic sum;
    } t_dp_cmd;

    // floor(x / 100) for x below 25600
    function automatic logic [Q100_W-1:0] div100(input logic [YY_W-1:0] x);
        logic [D100_P_W-1:0] p;
        p = D100_P_W'(x) * D100_P_W'(D100_MUL);
        return p[D100_SHIFT +: Q100_W];
    endfunction

    // floor(x / 7) for x below 2^23
    function automatic logic [QUOT_W-1:0] div7(input logic [SER_W-1:0] x);
        logic [D7_P_W-1:0] p;
        p = D7_P_W'(x) * D7_P_W'(D7_MUL);
        return p[D7_SHIFT +: QUOT_W];
    endfunction

    // x - 7 * q, where q = floor(x / 7)
    function automatic logic [WD_W-1:0] mod7(input logic [SER_W-1:0] x,
                                             input logic [QUOT_W-1:0] q);
        logic [SER_W-1:0] t;
        t = x - ((SER_W'(q) << 3) - SER_W'(q));
        return t[WD_W-1:0];
    endfunction

    // zero for a month outside 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days before a month, counted from March
    function automatic logic [MOFF_W-1:0] month_offset(input logic [MM_W-1:0] mm);
        logic [MOFF_W-1:0] off;
        case (mm)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

/* sv/bdc_if.sv */
// ----------------------------------------------------------------------------
// Business day counter channels
// Valid/ready channels for date pairs, results and the weekend mask write.
// ----------------------------------------------------------------------------
interface bdc_in_if import bdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DAY_W-1:0]  start_day;
    logic [MON_W-1:0]  start_month;
    logic [YEAR_W-1:0] start_year;
    logic [DAY_W-1:0]  end_day;
    logic [MON_W-1:0]  end_month;
    logic [YEAR_W-1:0] end_year;

    modport source (output valid, start_day, start_month, start_year,
                    end_day, end_month, end_year, input ready);
    modport sink (input valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, output ready);
endinterface

interface bdc_out_if import bdc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] business_days;
    logic               date_invalid;

    modport source (output valid, business_days, date_invalid, input ready);
    modport sink (input valid, business_days, date_invalid, output ready);
endinterface

interface bdc_cfg_if import bdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] weekend_mask;

    modport source (output valid, weekend_mask, input ready);
    modport sink (input valid, weekend_mask, output ready);
endinterface

/* sv/bdc_ctrl.sv */
// ----------------------------------------------------------------------------
// Business day counter sequencer
// Takes one date pair, steps the datapath through its stages and holds the
// result until the transfer on the output side.
// ----------------------------------------------------------------------------
module bdc_ctrl import bdc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_YEAR;
                end
            end
            ST_YEAR: begin
                o_cmd.year = 1'b1;
                n_state    = ST_SERIAL;
            end
            ST_SERIAL: begin
                o_cmd.serial = 1'b1;
                n_state      = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = ST_REM;
            end
            ST_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/bdc_dp.sv */
// ----------------------------------------------------------------------------
// Business day counter datapath
// Day serials of both dates, validity, span length, weekday split and the
// final count, one registered step per sequencer command.
// ----------------------------------------------------------------------------
module bdc_dp import bdc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    bdc_in_if.sink           i_in,
    bdc_cfg_if.sink          i_cfg,
    bdc_out_if.source        o_out
);

    logic [MASK_W-1:0]  r_mask;

    logic [DAY_W-1:0]   r_d  [2];
    logic [MON_W-1:0]   r_m  [2];
    logic [YEAR_W-1:0]  r_y  [2];

    logic [YY_W-1:0]    r_yl [2];
    logic [YY_W-1:0]    r_yy [2];
    logic [Q100_W-1:0]  r_ql [2];
    logic [Q100_W-1:0]  r_qy [2];
    logic [MM_W-1:0]    r_mm [2];
    logic [YY_W-1:0]    n_yl [2];
    logic [YY_W-1:0]    n_yy [2];
    logic [MM_W-1:0]    n_mm [2];

    logic [SER_W-1:0]   r_ser [2];
    logic [SER_W-1:0]   n_ser [2];
    logic               r_invalid;
    logic               n_invalid;

    logic [SER_W-1:0]   r_n;
    logic [SER_W-1:0]   r_wsrc;
    logic [QUOT_W-1:0]  r_nq;
    logic [QUOT_W-1:0]  r_wq;
    logic [WD_W-1:0]    r_nr;
    logic [WD_W-1:0]    r_wd;
    logic [FULL_W-1:0]  r_full;
    logic [WD_W-1:0]    n_busy;
    logic [COUNT_W-1:0] r_business_days;
    logic [COUNT_W-1:0] n_business_days;
    logic               r_date_invalid;

    assign i_cfg.ready         = 1'b1;
    assign o_out.business_days = r_business_days;
    assign o_out.date_invalid  = r_date_invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (i_cfg.valid) begin
            r_mask <= i_cfg.weekend_mask;
        end
    end

    // year split: shifted year, March-based month and the centuries
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_yl[k] = YY_W'(r_y[k]) + YY_W'(YEAR_BIAS);
            if (r_m[k] <= MON_W'(2)) begin
                n_yy[k] = n_yl[k] - YY_W'(1);
                n_mm[k] = MM_W'(r_m[k] + MON_W'(9));
            end else begin
                n_yy[k] = n_yl[k];
                n_mm[k] = MM_W'(r_m[k] - MON_W'(3));
            end
        end
    end

    // day serial and date check
    always_comb begin
        logic ok [2];
        logic leap;
        for (int k = 0; k < 2; k++) begin
            if (r_yl[k] == YY_W'(r_ql[k]) * YY_W'(100)) begin
                leap = (r_ql[k][1:0] == 2'd0);
            end else begin
                leap = (r_yl[k][1:0] == 2'd0);
            end
            ok[k]    = (r_d[k] != '0) && (r_d[k] <= month_days(r_m[k], leap));
            n_ser[k] = SER_W'(r_yy[k]) * SER_W'(DAYS_PER_YEAR)
                     + SER_W'(r_yy[k] >> 2)
                     - SER_W'(r_qy[k])
                     + SER_W'(r_qy[k] >> 2)
                     + SER_W'(month_offset(r_mm[k]))
                     + SER_W'(r_d[k]) - SER_W'(1);
        end
        n_invalid = !(ok[0] && ok[1]);
    end

    // business days per full week
    always_comb begin
        n_busy = '0;
        for (int i = 0; i < WEEK_DAYS; i++) begin
            n_busy = n_busy + WD_W'(!r_mask[i]);
        end
    end

    // partial week, saturation and zero count for an invalid date
    always_comb begin
        logic [WD_W:0]     idx;
        logic [WD_W-1:0]   extra;
        logic [FULL_W-1:0] total;
        extra = '0;
        for (int i = 0; i < WEEK_DAYS; i++) begin
            idx = (WD_W+1)'(r_wd) + (WD_W+1)'(i);
            if (idx >= (WD_W+1)'(WEEK_DAYS)) begin
                idx = idx - (WD_W+1)'(WEEK_DAYS);
            end
            if ((WD_W'(i) < r_nr) && !r_mask[idx[WD_W-1:0]]) begin
                extra = extra + WD_W'(1);
            end
        end
        total = r_full + FULL_W'(extra);
        if (r_invalid) begin
            n_business_days = '0;
        end else if (total > FULL_W'(COUNT_MAX)) begin
            n_business_days = COUNT_MAX;
        end else begin
            n_business_days = total[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d[0] <= i_in.start_day;
            r_m[0] <= i_in.start_month;
            r_y[0] <= i_in.start_year;
            r_d[1] <= i_in.end_day;
            r_m[1] <= i_in.end_month;
            r_y[1] <= i_in.end_year;
        end
        if (i_cmd.year) begin
            for (int k = 0; k < 2; k++) begin
                r_yl[k] <= n_yl[k];
                r_yy[k] <= n_yy[k];
                r_mm[k] <= n_mm[k];
                r_ql[k] <= div100(n_yl[k]);
                r_qy[k] <= div100(n_yy[k]);
            end
        end
        if (i_cmd.serial) begin
            r_ser[0]  <= n_ser[0];
            r_ser[1]  <= n_ser[1];
            r_invalid <= n_invalid;
        end
        if (i_cmd.diff) begin
            r_n    <= (r_ser[0] < r_ser[1]) ? (r_ser[1] - r_ser[0]) : '0;
            r_wsrc <= r_ser[0] + SER_W'(EPOCH_WD);
        end
        if (i_cmd.div) begin
            r_nq <= div7(r_n);
            r_wq <= div7(r_wsrc);
        end
        if (i_cmd.rem) begin
            r_nr   <= mod7(r_n, r_nq);
            r_wd   <= mod7(r_wsrc, r_wq);
            r_full <= FULL_W'(r_nq) * FULL_W'(n_busy);
        end
        if (i_cmd.sum) begin
            r_business_days <= n_business_days;
            r_date_invalid  <= r_invalid;
        end
    end

endmodule

/* sv/business_day_counter.sv */
// ----------------------------------------------------------------------------
// Business day counter
// Counts the non-weekend days from a start date up to, but not including, an end date.
// The date pair is registered, then stepped through the year, serial, diff, div,
// rem and sum steps of the sequencer before the result is valid.
// A new pair is taken once the previous result has been transferred.
// Reset clears the sequencer and sets the weekend mask to Friday and Saturday.
// ----------------------------------------------------------------------------
module business_day_counter import bdc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdc_in_if.sink    i_in,
    bdc_cfg_if.sink   i_cfg,
    bdc_out_if.source o_out
);

    t_dp_cmd cmd;
    logic    in_ready;
    logic    out_valid;

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    bdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    bdc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule
